### sv/pwpc_pkg.sv
package pwpc_pkg;

    localparam int DEBOUNCE_TICKS_DEF = 20;
    localparam int CNT_W              = 16;
    localparam int APB_AW             = 5;
    localparam int APB_DW             = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes
    typedef enum logic [2:0] {
        REG_ON_LEVEL   = 3'd0,
        REG_PWR_START  = 3'd1,
        REG_WAIT_MS    = 3'd2,
        REG_OFF_MS     = 3'd3,
        REG_MIN_WIDTH  = 3'd4,
        REG_MAX_WIDTH  = 3'd5
    } t_reg_idx;

    // phase codes on the result
    localparam logic [1:0] PH_CODE_IDLE     = 2'd0;
    localparam logic [1:0] PH_CODE_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_CODE_WAIT     = 2'd2;
    localparam logic [1:0] PH_CODE_OFF      = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DEBOUNCE = 4'b0010,
        ST_WAIT     = 4'b0100,
        ST_OFF      = 4'b1000
    } t_phase;

    typedef struct packed {
        logic             on_level;
        logic             power_on_at_start;
        logic [CNT_W-1:0] wait_ms;
        logic [CNT_W-1:0] off_ms;
        logic [CNT_W-1:0] min_width;
        logic [CNT_W-1:0] max_width;
    } t_cfg;

    typedef struct packed {
        logic       drive;
        logic [1:0] phase;
        logic       cycle_start;
    } t_result;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

### sv/pwpc_cfg.sv
module pwpc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pwpc_pkg::APB_AW-1:0]  paddr,
    input  logic [pwpc_pkg::APB_DW-1:0]  pwdata,
    output logic [pwpc_pkg::APB_DW-1:0]  prdata,
    output pwpc_pkg::t_cfg               o_cfg
);
    import pwpc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_level          <= 1'b0;
            r_cfg.power_on_at_start <= 1'b1;
            r_cfg.wait_ms           <= CNT_W'(3000);
            r_cfg.off_ms            <= CNT_W'(3000);
            r_cfg.min_width         <= CNT_W'(100);
            r_cfg.max_width         <= CNT_W'(500);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ON_LEVEL:  r_cfg.on_level          <= pwdata[0];
                REG_PWR_START: r_cfg.power_on_at_start <= pwdata[0];
                REG_WAIT_MS:   r_cfg.wait_ms           <= pwdata[CNT_W-1:0];
                REG_OFF_MS:    r_cfg.off_ms            <= pwdata[CNT_W-1:0];
                REG_MIN_WIDTH: r_cfg.min_width         <= pwdata[CNT_W-1:0];
                REG_MAX_WIDTH: r_cfg.max_width         <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_ON_LEVEL:  prdata[0]         = r_cfg.on_level;
            REG_PWR_START: prdata[0]         = r_cfg.power_on_at_start;
            REG_WAIT_MS:   prdata[CNT_W-1:0] = r_cfg.wait_ms;
            REG_OFF_MS:    prdata[CNT_W-1:0] = r_cfg.off_ms;
            REG_MIN_WIDTH: prdata[CNT_W-1:0] = r_cfg.min_width;
            REG_MAX_WIDTH: prdata[CNT_W-1:0] = r_cfg.max_width;
            default:       prdata            = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/pwpc_step.sv
module pwpc_step #(
    parameter int DEBOUNCE_TICKS = pwpc_pkg::DEBOUNCE_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_pin,
    input  logic              i_req,
    input  pwpc_pkg::t_cfg    i_cfg,
    output pwpc_pkg::t_result o_res
);
    import pwpc_pkg::*;

    localparam logic [CNT_W-1:0] DEB = CNT_W'(DEBOUNCE_TICKS);

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_phase_count, n_phase_count;
    logic [CNT_W-1:0] r_width_count, n_width_count;
    logic [CNT_W-1:0] r_edge_width, n_edge_width;
    logic             r_last_pin, n_last_pin;
    logic             r_rise_seen, n_rise_seen;
    logic             r_has_cycled, n_has_cycled;
    logic [CNT_W-1:0] w_wc_inc, w_pc_inc;
    logic             w_start;

    assign w_wc_inc = count_up(r_width_count);
    assign w_pc_inc = count_up(r_phase_count);

    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_width_count = w_wc_inc;
        n_edge_width  = r_edge_width;
        n_rise_seen   = r_rise_seen;
        n_has_cycled  = r_has_cycled;
        n_last_pin    = i_pin;
        w_start       = 1'b0;
        unique case (r_phase)
            ST_IDLE: begin
                if (i_req) begin
                    n_phase       = ST_WAIT;
                    n_phase_count = '0;
                    w_start       = 1'b1;
                end else if (i_pin != r_last_pin) begin
                    n_edge_width  = w_wc_inc;
                    n_phase       = ST_DEBOUNCE;
                    n_phase_count = '0;
                end
            end
            ST_DEBOUNCE: begin
                n_phase_count = w_pc_inc;
                if (w_pc_inc >= DEB) begin
                    n_phase_count = '0;
                    n_phase       = ST_IDLE;
                    if (i_pin) begin
                        n_rise_seen   = 1'b1;
                        n_width_count = DEB;
                    end else begin
                        if (r_rise_seen && r_edge_width > i_cfg.min_width &&
                            r_edge_width < i_cfg.max_width) begin
                            n_phase = ST_WAIT;
                            w_start = 1'b1;
                        end
                        n_rise_seen = 1'b0;
                    end
                end
            end
            ST_WAIT: begin
                n_phase_count = w_pc_inc;
                if (w_pc_inc >= i_cfg.wait_ms) begin
                    n_phase       = ST_OFF;
                    n_phase_count = '0;
                end
            end
            ST_OFF: begin
                n_phase_count = w_pc_inc;
                if (w_pc_inc >= i_cfg.off_ms) begin
                    n_phase       = ST_IDLE;
                    n_phase_count = '0;
                    n_has_cycled  = 1'b1;
                    n_rise_seen   = 1'b0;
                end
            end
            default: begin
                n_phase       = ST_IDLE;
                n_phase_count = '0;
            end
        endcase
    end

    always_comb begin
        o_res.cycle_start = w_start;
        unique case (n_phase)
            ST_IDLE:     o_res.phase = PH_CODE_IDLE;
            ST_DEBOUNCE: o_res.phase = PH_CODE_DEBOUNCE;
            ST_WAIT:     o_res.phase = PH_CODE_WAIT;
            ST_OFF:      o_res.phase = PH_CODE_OFF;
            default:     o_res.phase = PH_CODE_IDLE;
        endcase
        if (n_phase == ST_OFF) begin
            o_res.drive = ~i_cfg.on_level;
        end else if (n_has_cycled || i_cfg.power_on_at_start) begin
            o_res.drive = i_cfg.on_level;
        end else begin
            o_res.drive = ~i_cfg.on_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ST_IDLE;
            r_phase_count <= '0;
            r_width_count <= '0;
            r_edge_width  <= '0;
            r_last_pin    <= 1'b0;
            r_rise_seen   <= 1'b0;
            r_has_cycled  <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_width_count <= n_width_count;
            r_edge_width  <= n_edge_width;
            r_last_pin    <= n_last_pin;
            r_rise_seen   <= n_rise_seen;
            r_has_cycled  <= n_has_cycled;
        end
    end

endmodule

### sv/pulse_window_power_cycler.sv
// channel  | dir | handshake        | payload
// ---------+-----+------------------+----------------------------------------
// s_axis   | in  | tvalid / tready  | tdata[0] pin_sample, [1] reset_request
// m_axis   | out | tvalid / tready  | tdata[0] drive, [2:1] phase, [3] cycle_start
// apb      | in  | psel/penable     | 6 registers at 4*i, pready tied high
//
// One request per clock while the output is not stalled; each result passes through
// the input register, then the result register, before it is offered. Reset is
// synchronous and returns all control state and the configuration registers to
// their defaults. A stalled result holds in the output register while one more
// request waits in the input register.
module pulse_window_power_cycler #(
    parameter int DEBOUNCE_TICKS = pwpc_pkg::DEBOUNCE_TICKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [0] pin_sample, [1] reset_request
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [0] drive, [2:1] phase, [3] cycle_start
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwpc_pkg::APB_AW-1:0] paddr,
    input  logic [pwpc_pkg::APB_DW-1:0] pwdata,
    output logic [pwpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import pwpc_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    t_result r_out;
    logic    r_in_valid, r_in_pin, r_in_req;
    logic    r_out_valid;
    logic    w_adv;

    assign pready        = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    pwpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    pwpc_step #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_pin   (r_in_pin),
        .i_req   (r_in_req),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pin <= s_axis_tdata[0];
            r_in_req <= s_axis_tdata[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.cycle_start, r_out.phase, r_out.drive};

endmodule
